[hdl/stc_pkg.sv]
package stc_pkg;

    localparam int CHAR_IN_W   = 8;
    localparam int CHAR_W      = 7;
    localparam int PAGE_W      = 16;
    localparam int COL_W       = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;

    localparam int MAX_PENDING = 63;
    localparam int PEND_W      = $clog2(MAX_PENDING + 1);
    localparam int TAB_WIDTH   = 8;
    localparam int TAB_W       = $clog2(TAB_WIDTH);
    localparam int GAP_W       = TAB_W + 1;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = FIFO_AW + 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_NUMBER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_PAGE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_PAGE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLAIN_SPACES = 2'd3;

    localparam logic [PAGE_W-1:0] PAGE_NUMBER_RST  = 16'd1;
    localparam logic [PAGE_W-1:0] FIRST_PAGE_RST   = 16'd0;
    localparam logic [PAGE_W-1:0] LAST_PAGE_RST    = 16'd9999;
    localparam logic              PLAIN_SPACES_RST = 1'b1;

    localparam logic [CHAR_W-1:0] CH_NUL = 7'd0;
    localparam logic [CHAR_W-1:0] CH_TAB = 7'd9;
    localparam logic [CHAR_W-1:0] CH_NL  = 7'd10;
    localparam logic [CHAR_W-1:0] CH_SP  = 7'd32;

    // Command kinds passed from the front to the back.
    localparam logic [1:0] KIND_SPACE = 2'd0;
    localparam logic [1:0] KIND_NL    = 2'd1;
    localparam logic [1:0] KIND_CHAR  = 2'd2;

    typedef struct packed {
        logic [PAGE_W-1:0] page_number;
        logic [PAGE_W-1:0] first_page;
        logic [PAGE_W-1:0] last_page;
        logic              plain_spaces;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CHAR_W-1:0] ch;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } push_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

endpackage

[hdl/stc_in_if.sv]
interface stc_in_if;
    logic                          valid;
    logic                          ready;
    logic [stc_pkg::CHAR_IN_W-1:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

[hdl/stc_out_if.sv]
interface stc_out_if;
    logic                       valid;
    logic                       ready;
    logic [stc_pkg::CHAR_W-1:0] char_out;
    logic                       last;

    modport source (output valid, output char_out, output last, input ready);
    modport sink (input valid, input char_out, input last, output ready);
endinterface

[hdl/stc_front.sv]
module stc_front (
    stc_in_if.sink             in_ch,
    input  stc_pkg::cfg_t      cfg,
    input  stc_pkg::fifo_stat_t fifo_stat,
    output stc_pkg::push_t     push
);

    logic                       in_range;
    logic [stc_pkg::CHAR_W-1:0] ch;
    logic                       accept;

    assign ch = in_ch.char_in[stc_pkg::CHAR_W-1:0];

    // A last page of zero lifts the upper bound.
    assign in_range = (cfg.page_number >= cfg.first_page) &&
                      ((cfg.last_page == '0) || (cfg.page_number <= cfg.last_page));

    assign in_ch.ready = !fifo_stat.full;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        push.valid   = accept && in_range && (ch != stc_pkg::CH_NUL);
        push.cmd.ch  = ch;
        case (ch)
            stc_pkg::CH_SP:
            begin
                push.cmd.kind = stc_pkg::KIND_SPACE;
            end
            stc_pkg::CH_NL:
            begin
                push.cmd.kind = stc_pkg::KIND_NL;
            end
            default:
            begin
                push.cmd.kind = stc_pkg::KIND_CHAR;
            end
        endcase
    end

endmodule

[hdl/stc_fifo.sv]
module stc_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  stc_pkg::push_t       push,
    input  logic                 pop,
    output stc_pkg::cmd_t        head,
    output stc_pkg::fifo_stat_t  stat
);

    stc_pkg::cmd_t                 mem_reg [stc_pkg::FIFO_DEPTH];
    logic [stc_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [stc_pkg::FIFO_AW-1:0]   wr_ptr_next;
    logic [stc_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [stc_pkg::FIFO_AW-1:0]   rd_ptr_next;
    logic [stc_pkg::FIFO_CW-1:0]   count_reg;
    logic [stc_pkg::FIFO_CW-1:0]   count_next;
    logic                          do_push;
    logic                          do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == stc_pkg::FIFO_CW'(stc_pkg::FIFO_DEPTH));
    assign do_push    = push.valid && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

[hdl/stc_back.sv]
module stc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  stc_pkg::cfg_t       cfg,
    input  stc_pkg::cmd_t       head,
    input  stc_pkg::fifo_stat_t fifo_stat,
    output logic                pop,
    stc_out_if.source           out_ch
);

    logic [stc_pkg::PEND_W-1:0] pending_reg;
    logic [stc_pkg::PEND_W-1:0] pending_next;
    logic [stc_pkg::COL_W-1:0]  column_reg;
    logic [stc_pkg::COL_W-1:0]  column_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [stc_pkg::CHAR_W-1:0] char_out_reg;
    logic [stc_pkg::CHAR_W-1:0] char_out_next;
    logic                       last_reg;
    logic                       last_next;
    logic                       can_emit;
    logic                       emit;
    logic [stc_pkg::GAP_W-1:0]  gap;
    logic                       tab_fits;

    // The output register is free when empty or being taken this cycle.
    assign can_emit = !out_valid_reg || out_ch.ready;

    // Distance to the next tab stop, one to TAB_WIDTH columns.
    assign gap = stc_pkg::GAP_W'(stc_pkg::TAB_WIDTH) -
                 {1'b0, column_reg[stc_pkg::TAB_W-1:0]};
    assign tab_fits = !cfg.plain_spaces &&
                      (stc_pkg::PEND_W'(gap) <= pending_reg);

    always_comb
    begin
        pending_next  = pending_reg;
        column_next   = column_reg;
        char_out_next = char_out_reg;
        last_next     = last_reg;
        emit          = 1'b0;
        pop           = 1'b0;
        if (!fifo_stat.empty)
        begin
            case (head.kind)
                stc_pkg::KIND_SPACE:
                begin
                    pop = 1'b1;
                    if (pending_reg != stc_pkg::PEND_W'(stc_pkg::MAX_PENDING))
                    begin
                        pending_next = pending_reg + 1'b1;
                    end
                end
                stc_pkg::KIND_NL:
                begin
                    if (can_emit)
                    begin
                        pop           = 1'b1;
                        emit          = 1'b1;
                        char_out_next = stc_pkg::CH_NL;
                        last_next     = 1'b1;
                        pending_next  = '0;
                        column_next   = '0;
                    end
                end
                default:
                begin
                    if (can_emit)
                    begin
                        emit = 1'b1;
                        if (pending_reg != '0)
                        begin
                            // Release one pending space or tab per cycle while the output register is free.
                            last_next = 1'b0;
                            if (tab_fits)
                            begin
                                char_out_next = stc_pkg::CH_TAB;
                                pending_next  = pending_reg - stc_pkg::PEND_W'(gap);
                                column_next   = column_reg + stc_pkg::COL_W'(gap);
                            end
                            else
                            begin
                                char_out_next = stc_pkg::CH_SP;
                                pending_next  = pending_reg - 1'b1;
                                column_next   = column_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            pop           = 1'b1;
                            char_out_next = head.ch;
                            last_next     = 1'b1;
                            column_next   = column_reg + 1'b1;
                        end
                    end
                end
            endcase
        end
        out_valid_next = emit || (out_valid_reg && !out_ch.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            column_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            column_reg    <= column_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_out_reg <= char_out_next;
        last_reg     <= last_next;
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.char_out = char_out_reg;
    assign out_ch.last     = last_reg;

endmodule

[hdl/space_to_tab_output_compressor.sv]
// Flow: the command queue is written at the edge that accepts an input word, and the output
// register is loaded from the queue head once it is free and earlier commands are done.
// Throughput: one input word per cycle while the four-entry command queue has room;
// a character holds the back end until its pending spaces or tabs and then itself are sent,
// one output word per cycle through the single output register while the receiver takes them.
// Reset (rst_n, asynchronous, active low) empties the queue and the output register,
// clears pending spaces and column, and loads the configuration reset values.
module space_to_tab_output_compressor (
    input  logic                            clk,
    input  logic                            rst_n,
    stc_in_if.sink                          in_ch,
    stc_out_if.source                       out_ch,
    input  logic                            cfg_we,
    input  logic [stc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [stc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [stc_pkg::PAGE_W-1:0] page_number_reg;
    logic [stc_pkg::PAGE_W-1:0] first_page_reg;
    logic [stc_pkg::PAGE_W-1:0] last_page_reg;
    logic                       plain_spaces_reg;
    stc_pkg::cfg_t              cfg;
    stc_pkg::push_t             push;
    stc_pkg::cmd_t              head;
    stc_pkg::fifo_stat_t        fifo_stat;
    logic                       pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_number_reg  <= stc_pkg::PAGE_NUMBER_RST;
            first_page_reg   <= stc_pkg::FIRST_PAGE_RST;
            last_page_reg    <= stc_pkg::LAST_PAGE_RST;
            plain_spaces_reg <= stc_pkg::PLAIN_SPACES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                stc_pkg::REG_PAGE_NUMBER:  page_number_reg  <= cfg_data[stc_pkg::PAGE_W-1:0];
                stc_pkg::REG_FIRST_PAGE:   first_page_reg   <= cfg_data[stc_pkg::PAGE_W-1:0];
                stc_pkg::REG_LAST_PAGE:    last_page_reg    <= cfg_data[stc_pkg::PAGE_W-1:0];
                stc_pkg::REG_PLAIN_SPACES: plain_spaces_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.page_number  = page_number_reg;
    assign cfg.first_page   = first_page_reg;
    assign cfg.last_page    = last_page_reg;
    assign cfg.plain_spaces = plain_spaces_reg;

    stc_front u_front (
        .in_ch     (in_ch),
        .cfg       (cfg),
        .fifo_stat (fifo_stat),
        .push      (push)
    );

    stc_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .stat  (fifo_stat)
    );

    stc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .head      (head),
        .fifo_stat (fifo_stat),
        .pop       (pop),
        .out_ch    (out_ch)
    );

    // A queued command is still there, or being worked on, in the next cycle.
    a_push_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |=> !fifo_stat.empty)
        else $error("queued command vanished");

    // Only released spaces and tabs come without the last mark.
    a_fill_chars: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.last) |->
            (out_ch.char_out == stc_pkg::CH_SP || out_ch.char_out == stc_pkg::CH_TAB))
        else $error("non-final word is not a space or tab");

    // A newline always closes its own run.
    a_nl_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.char_out == stc_pkg::CH_NL) |-> out_ch.last)
        else $error("newline without last mark");

endmodule

[bench/tb_space_to_tab_output_compressor.sv]
module tb_space_to_tab_output_compressor;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 24;

    typedef struct {
        logic [stc_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } emit_t;

    // Tracks the print range and the column to work out which words leave the block.
    class entab_tracker;
        logic [stc_pkg::PAGE_W-1:0] page_number;
        logic [stc_pkg::PAGE_W-1:0] first_page;
        logic [stc_pkg::PAGE_W-1:0] last_page;
        logic                       plain_spaces;
        logic [stc_pkg::PEND_W-1:0] held_spaces;
        logic [stc_pkg::COL_W-1:0]  column;
        emit_t                      due_words[$];
        int                         errors;

        function new();
            page_number  = stc_pkg::PAGE_NUMBER_RST;
            first_page   = stc_pkg::FIRST_PAGE_RST;
            last_page    = stc_pkg::LAST_PAGE_RST;
            plain_spaces = stc_pkg::PLAIN_SPACES_RST;
            held_spaces  = '0;
            column       = '0;
            errors       = 0;
        endfunction

        function void set_reg(logic [stc_pkg::CFG_IDX_W-1:0] idx,
                              logic [stc_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                stc_pkg::REG_PAGE_NUMBER:  page_number  = data[stc_pkg::PAGE_W-1:0];
                stc_pkg::REG_FIRST_PAGE:   first_page   = data[stc_pkg::PAGE_W-1:0];
                stc_pkg::REG_LAST_PAGE:    last_page    = data[stc_pkg::PAGE_W-1:0];
                stc_pkg::REG_PLAIN_SPACES: plain_spaces = data[0];
                default: ;
            endcase
        endfunction

        function void add_word(logic [stc_pkg::CHAR_W-1:0] ch, logic last);
            emit_t w;
            w.ch = ch;
            w.last = last;
            due_words.push_back(w);
        endfunction

        function void take_char(logic [stc_pkg::CHAR_IN_W-1:0] raw);
            logic [stc_pkg::CHAR_W-1:0] c;
            int                         gap;
            c = raw[stc_pkg::CHAR_W-1:0];
            if (page_number < first_page || (last_page != 0 && page_number > last_page))
                return;
            if (c == stc_pkg::CH_NUL)
                return;
            if (c == stc_pkg::CH_SP)
            begin
                if (held_spaces < stc_pkg::MAX_PENDING)
                    held_spaces++;
                return;
            end
            if (c == stc_pkg::CH_NL)
            begin
                held_spaces = '0;
                column = '0;
                add_word(stc_pkg::CH_NL, 1'b1);
                return;
            end
            while (held_spaces != 0)
            begin
                gap = stc_pkg::TAB_WIDTH - (column % stc_pkg::TAB_WIDTH);
                if (!plain_spaces && gap <= held_spaces)
                begin
                    add_word(stc_pkg::CH_TAB, 1'b0);
                    held_spaces = held_spaces - stc_pkg::PEND_W'(gap);
                    column = column + stc_pkg::COL_W'(gap);
                end
                else
                begin
                    add_word(stc_pkg::CH_SP, 1'b0);
                    held_spaces--;
                    column++;
                end
            end
            add_word(c, 1'b1);
            column++;
        endfunction

        function void check_word(logic [stc_pkg::CHAR_W-1:0] ch, logic last);
            emit_t w;
            if (due_words.size() == 0)
            begin
                $error("unexpected word: char_out %0d last %0d", ch, last);
                errors++;
                return;
            end
            w = due_words.pop_front();
            if (ch !== w.ch)
            begin
                $error("char_out expected %0d actual %0d", w.ch, ch);
                errors++;
            end
            if (last !== w.last)
            begin
                $error("last expected %0d actual %0d", w.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [stc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [stc_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           calm;
    logic                           hold_request;
    int                             cycle_count = 0;

    entab_tracker tracker = new();

    stc_in_if  in_ch();
    stc_out_if out_ch();

    space_to_tab_output_compressor DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Short directed text: masking, NUL, DEL, newline with spaces held, tabs to stops.
    logic [stc_pkg::CHAR_IN_W-1:0] spaced_text[] = '{
        8'h41, 8'h20, 8'h20, 8'h20, 8'h62, 8'h00, 8'h80, 8'hFF,
        8'hA0, 8'h20, 8'h0A, 8'hA0, 8'h8A, 8'h01, 8'h7E
    };
    logic [stc_pkg::CHAR_IN_W-1:0] tabbed_text[] = '{
        8'h20, 8'h20, 8'h20, 8'h20, 8'hA0, 8'h20, 8'h20, 8'h20, 8'h78,
        8'h20, 8'h20, 8'h20, 8'h79, 8'h09, 8'h20, 8'hA0, 8'h20, 8'h20, 8'h20, 8'hC1
    };

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("space_to_tab_output_compressor: mismatch");
            $finish;
        end
    end

    // Both handshakes are sampled here, on the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            tracker.check_word(out_ch.char_out, out_ch.last);
        if (rst_n && in_ch.valid && in_ch.ready)
            tracker.take_char(in_ch.char_in);
    end

    initial
    begin
        logic hold_done;
        hold_done = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (!calm && $urandom_range(99) < 9)
                out_ch.ready = 1'b0;
            else
                out_ch.ready = 1'b1;
        end
    end

    task automatic write_reg(input logic [stc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [stc_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        tracker.set_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_pages(input logic [stc_pkg::PAGE_W-1:0] page,
                             input logic [stc_pkg::PAGE_W-1:0] first,
                             input logic [stc_pkg::PAGE_W-1:0] final_page);
        write_reg(stc_pkg::REG_PAGE_NUMBER, page);
        write_reg(stc_pkg::REG_FIRST_PAGE, first);
        write_reg(stc_pkg::REG_LAST_PAGE, final_page);
    endtask

    task automatic send_char(input logic [stc_pkg::CHAR_IN_W-1:0] c);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 9)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.char_in = c;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // Mostly words separated by runs of spaces and newlines, with some raw noise.
    task automatic send_text(input int count);
        int   sent;
        int   pick;
        int   run;
        logic top;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            top = 1'($urandom_range(1));
            if (pick < 30)
            begin
                run = ($urandom_range(99) < 4) ? $urandom_range(70, 56) : $urandom_range(12, 1);
                for (int k = 0; k < run; k++)
                begin
                    top = 1'($urandom_range(1));
                    send_char({top, stc_pkg::CH_SP});
                end
                sent += run;
            end
            else
            begin
                if (pick < 82)
                    send_char({top, 7'($urandom_range(126, 33))});
                else if (pick < 90)
                    send_char({top, stc_pkg::CH_NL});
                else if (pick < 96)
                    send_char(8'($urandom()));
                else
                    send_char({top, stc_pkg::CH_NUL});
                sent++;
            end
        end
    endtask

    // Drop valid, wait for every expected word, then give queued spaces time to drain.
    task automatic settle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (tracker.due_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [stc_pkg::PAGE_W-1:0] page;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = stc_pkg::REG_PAGE_NUMBER;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.char_in = '0;
        calm = 1'b0;
        hold_request = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (spaced_text[i])
            send_char(spaced_text[i]);
        settle();

        write_reg(stc_pkg::REG_PLAIN_SPACES, 16'h0000);
        foreach (tabbed_text[i])
            send_char(tabbed_text[i]);
        settle();

        // Page 0 with no upper limit, and no idling on either side.
        set_pages(16'd0, 16'd0, 16'd0);
        calm = 1'b1;
        send_text(40);
        settle();
        calm = 1'b0;

        // Top page, upper bits of the mode word ignored; saturate the space count,
        // then hold off the receiver while the input keeps coming.
        set_pages(16'hFFFF, 16'hFFFF, 16'd0);
        write_reg(stc_pkg::REG_PLAIN_SPACES, 16'hFFFE);
        for (int k = 0; k < 66; k++)
            send_char({1'b0, stc_pkg::CH_SP});
        send_char(8'h5A);
        hold_request = 1'b1;
        send_text(40);
        settle();

        // Pages below and above the range print nothing.
        set_pages(16'd5, 16'd6, 16'd9999);
        send_text(8);
        settle();
        set_pages(16'hFFFF, 16'd0, 16'hFFFE);
        send_text(8);
        settle();

        set_pages(16'd100, 16'd100, 16'd100);
        write_reg(stc_pkg::REG_PLAIN_SPACES, 16'hFFFF);
        send_text(30);
        settle();

        for (int p = 0; p < 3; p++)
        begin
            page = stc_pkg::PAGE_W'($urandom_range(16'hFFFF));
            set_pages(page, stc_pkg::PAGE_W'($urandom_range(page)),
                      $urandom_range(1) ? 16'd0 :
                          stc_pkg::PAGE_W'($urandom_range(16'hFFFF, page)));
            write_reg(stc_pkg::REG_PLAIN_SPACES, stc_pkg::CFG_DATA_W'($urandom()));
            send_text(10);
            settle();
        end

        if (tracker.errors == 0)
            $display("space_to_tab_output_compressor: match");
        else
            $display("space_to_tab_output_compressor: mismatch");
        $finish;
    end

endmodule
